// File: hw/rtl/sqe_pkg.sv
package sqe_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned OpWidth    = 2;
  localparam int unsigned ErrWidth   = 3;
  localparam int unsigned CountWidth = 7;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SWAP = 2'd2,
    OP_PEEK = 2'd3
  } op_e;

  typedef enum logic [ErrWidth-1:0] {
    ERR_OK         = 3'd0,
    ERR_POP_EMPTY  = 3'd1,
    ERR_SWAP_SHORT = 3'd2,
    ERR_PEEK_EMPTY = 3'd3,
    ERR_PUSH_FULL  = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_TOP,
    CMD_POP,
    CMD_SWAP,
    CMD_APPEND
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic sel;
    logic from_below;
  } cell_ctl_t;

endpackage

// File: hw/rtl/sqe_cell.sv
module sqe_cell (
  input  logic                              clk_i,
  input  sqe_pkg::cell_ctl_t                ctl_i,
  input  logic [sqe_pkg::DataWidth-1:0]     ins_i,
  input  logic [sqe_pkg::DataWidth-1:0]     up_i,
  input  logic [sqe_pkg::DataWidth-1:0]     down_i,
  output logic [sqe_pkg::DataWidth-1:0]     q_o
);
  import sqe_pkg::*;

  logic [DataWidth-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.cmd)
      CMD_HOLD:     data_d = data_q;
      CMD_PUSH_TOP: data_d = ctl_i.sel ? ins_i : up_i;
      CMD_POP:      data_d = down_i;
      CMD_SWAP: begin
        if (ctl_i.sel) begin
          data_d = ctl_i.from_below ? down_i : up_i;
        end
      end
      CMD_APPEND: begin
        if (ctl_i.sel) begin
          data_d = ins_i;
        end
      end
      default:      data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

// File: hw/rtl/stack_queue_engine.sv
// Bounded stack or queue of DEPTH signed 32-bit entries held in a row of cells, top entry in
// the first cell. An item is taken whenever start is high (busy stays low) and updates every
// cell in that same cycle, so a new item can follow in every cycle; its result appears on the
// following cycle for exactly one cycle, marked by done, and must be captured then because
// the block cannot wait. Pushes shift the row towards the bottom in stack mode and load the
// first free cell in queue mode; pops shift the row towards the top. Errors leave the contents
// unchanged and report the untouched state. Write queue_mode only while no item is in flight;
// the block does not enforce it. Entries read back are only those written since reset.
module stack_queue_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              queue_mode_we_i,
  input  logic                              queue_mode_i,
  input  logic                              start,
  output logic                              busy,
  input  logic [sqe_pkg::OpWidth-1:0]       opcode_i,
  input  logic signed [sqe_pkg::DataWidth-1:0] push_value_i,
  output logic                              done_o,
  output logic signed [sqe_pkg::DataWidth-1:0] top_value_o,
  output logic                              top_valid_o,
  output logic [sqe_pkg::ErrWidth-1:0]      error_code_o,
  output logic [sqe_pkg::CountWidth-1:0]    entry_count_o
);
  import sqe_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                 queue_mode_q;
  logic [CntW-1:0]      count_d, count_q;
  logic                 done_q;
  err_e                 err_d, err_q;
  cmd_e                 cmd;
  logic                 take;
  logic                 empty, full, short;
  logic [DataWidth-1:0] cell_q [DEPTH];
  cell_ctl_t            ctl [DEPTH];

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(DEPTH));
  assign short = (count_q < CntW'(2));

  always_comb begin
    cmd     = CMD_HOLD;
    err_d   = ERR_OK;
    count_d = count_q;
    unique case (op_e'(opcode_i))
      OP_PUSH: begin
        if (full) begin
          err_d = ERR_PUSH_FULL;
        end else begin
          cmd     = queue_mode_q ? CMD_APPEND : CMD_PUSH_TOP;
          count_d = count_q + CntW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          err_d = ERR_POP_EMPTY;
        end else begin
          cmd     = CMD_POP;
          count_d = count_q - CntW'(1);
        end
      end
      OP_SWAP: begin
        if (short) begin
          err_d = ERR_SWAP_SHORT;
        end else begin
          cmd = CMD_SWAP;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          err_d = ERR_PEEK_EMPTY;
        end
      end
      default: err_d = ERR_OK;
    endcase
    if (!take) begin
      cmd     = CMD_HOLD;
      count_d = count_q;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataWidth-1:0] up, down;

    always_comb begin
      ctl[i].cmd        = cmd;
      ctl[i].from_below = (i == 0);
      unique case (cmd)
        CMD_PUSH_TOP: ctl[i].sel = (i == 0);
        CMD_SWAP:     ctl[i].sel = (i < 2);
        CMD_APPEND:   ctl[i].sel = (count_q == CntW'(i));
        default:      ctl[i].sel = 1'b0;
      endcase
    end

    if (i == 0) begin : g_first
      assign up = push_value_i;
    end else begin : g_mid
      assign up = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign down = cell_q[i];
    end else begin : g_inner
      assign down = cell_q[i+1];
    end

    sqe_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[i]),
      .ins_i  (push_value_i),
      .up_i   (up),
      .down_i (down),
      .q_o    (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_mode_q <= 1'b0;
      count_q      <= '0;
      done_q       <= 1'b0;
      err_q        <= ERR_OK;
    end else begin
      if (queue_mode_we_i) begin
        queue_mode_q <= queue_mode_i;
      end
      count_q <= count_d;
      done_q  <= take;
      if (take) begin
        err_q <= err_d;
      end
    end
  end

  assign done_o        = done_q;
  assign top_valid_o   = !empty;
  assign top_value_o   = empty ? '0 : cell_q[0];
  assign error_code_o  = err_q;
  assign entry_count_o = CountWidth'(count_q);

endmodule

// File: hw/rtl/sqe_checker.sv
module sqe_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              queue_mode_we_i,
  input logic                              queue_mode_i,
  input logic                              start,
  input logic                              busy,
  input logic [sqe_pkg::OpWidth-1:0]       opcode_i,
  input logic [sqe_pkg::DataWidth-1:0]     push_value_i,
  input logic                              done_o,
  input logic [sqe_pkg::DataWidth-1:0]     top_value_o,
  input logic                              top_valid_o,
  input logic [sqe_pkg::ErrWidth-1:0]      error_code_o,
  input logic [sqe_pkg::CountWidth-1:0]    entry_count_o
);
  import sqe_pkg::*;

  // every transfer in gives one result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o)
    else $error("missing result after transfer");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !top_valid_o |-> top_value_o == '0)
    else $error("empty store shows non-zero top");

  a_error_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && error_code_o != ERR_OK |-> $stable(entry_count_o) && $stable(top_value_o)
      && $stable(top_valid_o))
    else $error("error result changed state");

  a_pop_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (error_code_o == ERR_POP_EMPTY || error_code_o == ERR_PEEK_EMPTY)
      |-> !top_valid_o)
    else $error("empty error with entries held");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> error_code_o <= ERR_PUSH_FULL)
    else $error("unknown error code");

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (.*);
